// File: design/e2r_pkg.sv
package e2r_pkg;

	// fixed internal formats
	localparam int CORDIC_STEPS = 16;
	localparam int IFRAC        = 30;
	localparam int OUT_WIDTH    = 16;

	// convention register codes
	localparam logic [1:0] CONV_INTR_123 = 2'd0;
	localparam logic [1:0] CONV_INTR_321 = 2'd1;
	localparam logic [1:0] CONV_EXTR_321 = 2'd2;

	// cordic start value: gain compensation in q30
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;

	// atan(2^-i), 2^32 per turn
	localparam logic signed [32:0] ATAN_TAB [CORDIC_STEPS] = '{
		33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
		33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
		33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
		33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D
	};

	typedef logic signed [31:0] q30_t;

	// cosine and sine of roll, pitch and yaw
	typedef struct packed {
		q30_t [2:0] c;
		q30_t [2:0] s;
	} trig_t;

	// row-major 3x3 matrix, entry i*3+j
	typedef q30_t [8:0] mat_t;

	// active right-hand rotation about one axis
	function automatic mat_t elem_rot(input int axis, input q30_t c, input q30_t s);
		mat_t m;
		int u;
		int v;
		m = '0;
		u = (axis + 1) % 3;
		v = (axis + 2) % 3;
		m[axis * 4] = Q30_ONE;
		m[u * 4]    = c;
		m[v * 4]    = c;
		m[u * 3 + v] = -s;
		m[v * 3 + u] = s;
		return m;
	endfunction

endpackage

// File: design/e2r_angle_if.sv
interface e2r_angle_if #(parameter int WIDTH = 16);
	logic              valid;
	logic              ready;
	logic [WIDTH-1:0]  roll;
	logic [WIDTH-1:0]  pitch;
	logic [WIDTH-1:0]  yaw;

	modport source (output valid, output roll, output pitch, output yaw, input ready);
	modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

// File: design/e2r_matrix_if.sv
interface e2r_matrix_if;
	logic        valid;
	logic        ready;
	logic [15:0] r00;
	logic [15:0] r01;
	logic [15:0] r02;
	logic [15:0] r10;
	logic [15:0] r11;
	logic [15:0] r12;
	logic [15:0] r20;
	logic [15:0] r21;
	logic [15:0] r22;

	modport source (output valid, output r00, output r01, output r02, output r10,
		output r11, output r12, output r20, output r21, output r22, input ready);
	modport sink   (input valid, input r00, input r01, input r02, input r10,
		input r11, input r12, input r20, input r21, input r22, output ready);
endinterface

// File: design/e2r_cfg_if.sv
interface e2r_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/e2r_front.sv
module e2r_front import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	e2r_angle_if.sink     angles,
	input  logic          q_full,
	output logic          push,
	output trig_t         push_data
);

	localparam int NST = CORDIC_STEPS;

	logic              en;
	logic [NST:0]      vld_q;
	logic [ANGLE_WIDTH-1:0] raw [3];
	q30_t              cos_w [3];
	q30_t              sin_w [3];

	// the pipeline only holds when a result waits and the queue is full
	assign en           = !q_full || !vld_q[NST];
	assign angles.ready = en;
	assign push         = vld_q[NST] && en;

	assign raw[0] = angles.roll;
	assign raw[1] = angles.pitch;
	assign raw[2] = angles.yaw;

	// valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:0], angles.valid && en};
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [31:0]        ang;
		logic [1:0]         quad;
		logic signed [32:0] z_in;
		logic signed [32:0] x_q [NST+1];
		logic signed [32:0] y_q [NST+1];
		logic signed [32:0] z_q [NST+1];
		logic [1:0]         quad_q [NST+1];
		logic signed [32:0] xo;
		logic signed [32:0] yo;

		// widen to a full-turn angle and fold into one quadrant
		assign ang  = 32'(raw[l]) << (32 - ANGLE_WIDTH);
		assign quad = ang[31:30] + 2'(ang[29]);
		assign z_in = 33'(signed'({ang[31:30] - quad, ang[29:0]}));

		// cordic rotation steps, one per stage
		always_ff @(posedge clk) begin
			if (en) begin
				x_q[0]    <= CORDIC_GAIN;
				y_q[0]    <= '0;
				z_q[0]    <= z_in;
				quad_q[0] <= quad;
				for (int i = 0; i < NST; i++) begin
					quad_q[i+1] <= quad_q[i];
					if (!z_q[i][32]) begin
						x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] - ATAN_TAB[i];
					end else begin
						x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] + ATAN_TAB[i];
					end
				end
			end
		end

		assign xo = x_q[NST];
		assign yo = y_q[NST];

		// put the folded quadrant back
		always_comb begin
			unique case (quad_q[NST])
				2'd0: begin cos_w[l] = xo[31:0];      sin_w[l] = yo[31:0];      end
				2'd1: begin cos_w[l] = 32'(-yo);      sin_w[l] = xo[31:0];      end
				2'd2: begin cos_w[l] = 32'(-xo);      sin_w[l] = 32'(-yo);      end
				default: begin cos_w[l] = yo[31:0];   sin_w[l] = 32'(-xo);      end
			endcase
		end
	end

	assign push_data.c = {cos_w[2], cos_w[1], cos_w[0]};
	assign push_data.s = {sin_w[2], sin_w[1], sin_w[0]};

endmodule

// File: design/e2r_queue.sv
module e2r_queue import e2r_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  trig_t push_data,
	output logic  full,
	input  logic  pop,
	output trig_t head,
	output logic  empty
);

	localparam int AW = $clog2(DEPTH);

	trig_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: design/e2r_back.sv
module e2r_back import e2r_pkg::*; #(
	parameter int ENTRY_FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    conv,
	input  logic          q_empty,
	input  trig_t         head,
	output logic          pop,
	e2r_matrix_if.source  matrix
);

	localparam int SH = IFRAC - ENTRY_FRAC_BITS;
	localparam logic signed [33:0] RND = 34'((64'd1 << SH) >> 1);
	localparam logic signed [33:0] LIM = 34'sd1 <<< ENTRY_FRAC_BITS;
	localparam logic signed [65:0] RND30 = 66'sd1 <<< (IFRAC - 1);

	logic [4:0]          vld_q;
	logic                en;
	mat_t                ma;
	mat_t                mb;
	mat_t                mc;
	logic signed [63:0]  prod_s1 [27];
	mat_t                mc_s1;
	q30_t                t_s2 [9];
	mat_t                mc_s2;
	logic signed [63:0]  prod_s3 [27];
	q30_t                res_s4 [9];
	logic [15:0]         out_s5 [9];
	logic signed [65:0]  acc2 [9];
	logic signed [65:0]  acc4 [9];
	logic signed [33:0]  fin [9];

	assign en           = !vld_q[4] || matrix.ready;
	assign pop          = !q_empty && en;
	assign matrix.valid = vld_q[4];

	// valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], pop};
		end
	end

	// factor order from the convention
	always_comb begin
		if (conv == CONV_INTR_321) begin
			ma = elem_rot(2, head.c[2], head.s[2]);
			mc = elem_rot(0, head.c[0], head.s[0]);
		end else begin
			ma = elem_rot(0, head.c[0], head.s[0]);
			mc = elem_rot(2, head.c[2], head.s[2]);
		end
		mb = elem_rot(1, head.c[1], head.s[1]);
	end

	// sums of products, rounded half up to q30, and the final rounding
	always_comb begin
		for (int n = 0; n < 9; n++) begin
			acc2[n] = 66'(prod_s1[n*3]) + 66'(prod_s1[n*3+1]) + 66'(prod_s1[n*3+2]) + RND30;
			acc4[n] = 66'(prod_s3[n*3]) + 66'(prod_s3[n*3+1]) + 66'(prod_s3[n*3+2]) + RND30;
			fin[n]  = (34'(res_s4[n]) + RND) >>> SH;
		end
	end

	// product pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s1[(i*3+j)*3+k] <= 64'(signed'(ma[i*3+k])) * 64'(signed'(mb[k*3+j]));
						prod_s3[(i*3+j)*3+k] <= 64'(signed'(t_s2[i*3+k])) * 64'(signed'(mc_s2[k*3+j]));
					end
				end
			end
			mc_s1 <= mc;
			mc_s2 <= mc_s1;
			for (int n = 0; n < 9; n++) begin
				t_s2[n]   <= acc2[n][61:30];
				res_s4[n] <= acc4[n][61:30];
				if (fin[n] > LIM) begin
					out_s5[n] <= LIM[15:0];
				end else if (fin[n] < -LIM) begin
					out_s5[n] <= 16'(-LIM);
				end else begin
					out_s5[n] <= fin[n][15:0];
				end
			end
		end
	end

	assign matrix.r00 = out_s5[0];
	assign matrix.r01 = out_s5[1];
	assign matrix.r02 = out_s5[2];
	assign matrix.r10 = out_s5[3];
	assign matrix.r11 = out_s5[4];
	assign matrix.r12 = out_s5[5];
	assign matrix.r20 = out_s5[6];
	assign matrix.r21 = out_s5[7];
	assign matrix.r22 = out_s5[8];

endmodule

// File: design/euler_to_rotation_matrix_core.sv
// Euler angles to rotation matrix.
// angles: roll, pitch and yaw as signed binary angles (2^(ANGLE_WIDTH-1) is pi),
//   taken when valid and ready are both high.
// matrix: the nine entries r00..r22 of the rotation matrix, row-major, signed with
//   ENTRY_FRAC_BITS fraction bits, saturated to plus or minus one.
// cfg: the convention register (0 intrinsic 1-2-3, 1 intrinsic 3-2-1,
//   2 extrinsic 3-2-1); always ready, write it only while the block is idle.
// Throughput: one request per cycle, sustained while the receiver takes results.
// Path with no stall: the accepting edge loads the first of 17 cordic stages in the
//   front end; the result is then written into the queue and passes the matrix product
//   back end (product, sum, product, sum and output registers), whose last stage is
//   the output register.
// A receiver stall holds the back end; the four-entry queue keeps the front end
//   running until it fills, then input ready drops.
// Reset clears all valid bits, the queue and the register (convention 0).
module euler_to_rotation_matrix_core import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH     = 16,
	parameter int ENTRY_FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	e2r_angle_if.sink     angles,
	e2r_matrix_if.source  matrix,
	e2r_cfg_if.sink       cfg
);

	logic       conv_q;
	logic [1:0] conv_reg_q;
	logic       push;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	trig_t      push_data;
	trig_t      head;

	assign cfg.ready = 1'b1;

	// convention register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_reg_q <= CONV_INTR_123;
			conv_q     <= 1'b0;
		end else if (cfg.valid) begin
			conv_reg_q <= cfg.data;
			conv_q     <= 1'b1;
		end
	end

	e2r_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.angles    (angles),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	e2r_queue #(.DEPTH(4)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	e2r_back #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.conv    (conv_q ? conv_reg_q : CONV_INTR_123),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.matrix  (matrix)
	);

endmodule
